// ----- rtl/shs_pkg.sv -----
// Shared types, constants and SHA-256 helper functions for the stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

   localparam int unsigned FILL_W   = 6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [FILL_W-1:0] LEN_FILL = 6'd56;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   // Standard initial hash value.
   localparam logic [31:0] INIT_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Round constants.
   localparam logic [31:0] ROUND_CONSTS [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Commands to the block buffer / message schedule.
   typedef struct packed {
      logic        byte_wr;
      logic [3:0]  word_sel;
      logic [7:0]  byte_val;
      logic        len_wr;
      logic [63:0] len_bits;
   } sched_cmd_type;

   // Commands to the compression core.
   typedef struct packed {
      logic       start;
      logic       reinit;
      logic [2:0] word_sel;
   } core_cmd_type;

   // Status from the compression core.
   typedef struct packed {
      logic done;
      logic shift;
   } core_sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/shs_sched.sv -----
// Block buffer that doubles as the sliding 16-word message schedule window.
`timescale 1ns / 1ps
`default_nettype none

module shs_sched (
   input  wire                    clock,
   input  shs_pkg::sched_cmd_type sched_cmd,
   input  wire                    shift,
   output logic [31:0]            sched_word
);
   import shs_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] next_word;

   // Next schedule word from the current window.
   assign next_word = small_sigma1(win_ff[14]) + win_ff[9]
                    + small_sigma0(win_ff[1]) + win_ff[0];

   assign sched_word = win_ff[0];

   // Byte packing, length insertion and schedule shifting.
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= next_word;
      end else if (sched_cmd.len_wr) begin
         win_ff[14] <= sched_cmd.len_bits[63:32];
         win_ff[15] <= sched_cmd.len_bits[31:0];
      end else if (sched_cmd.byte_wr) begin
         win_ff[sched_cmd.word_sel] <= {win_ff[sched_cmd.word_sel][23:0], sched_cmd.byte_val};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/shs_core.sv -----
// Compression core: one shared round unit iterated 64 times, plus chaining words.
`timescale 1ns / 1ps
`default_nettype none

module shs_core (
   input  wire                   clock,
   input  wire                   reset,
   input  shs_pkg::core_cmd_type core_cmd,
   input  wire  [31:0]           sched_word,
   output shs_pkg::core_sts_type core_sts,
   output logic [31:0]           chain_word
);
   import shs_pkg::*;

   typedef enum logic [1:0] {
      C_IDLE,
      C_RUN,
      C_ADD
   } core_state_type;

   core_state_type state_ff;
   logic [5:0]     round_ff;
   logic [31:0]    vars_ff  [8];
   logic [31:0]    chain_ff [8];
   logic           done_ff;

   logic [31:0] tmp1;
   logic [31:0] tmp2;
   logic [31:0] maj;
   logic [31:0] chs;

   // One SHA-256 round on the working variables.
   always_comb begin
      maj  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
           ^ (vars_ff[1] & vars_ff[2]);
      chs  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      tmp1 = vars_ff[7] + big_sigma1(vars_ff[4]) + chs
           + ROUND_CONSTS[round_ff] + sched_word;
      tmp2 = big_sigma0(vars_ff[0]) + maj;
   end

   assign core_sts.done  = done_ff;
   assign core_sts.shift = (state_ff == C_RUN);
   assign chain_word     = chain_ff[core_cmd.word_sel];

   // Round sequencer, working variables and chaining words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         round_ff <= '0;
         done_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_WORDS[i];
         end
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (core_cmd.reinit) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_ff[i] <= INIT_WORDS[i];
                  end
               end else if (core_cmd.start) begin
                  for (int i = 0; i < 8; i++) begin
                     vars_ff[i] <= chain_ff[i];
                  end
                  round_ff <= '0;
                  state_ff <= C_RUN;
               end
            end
            C_RUN: begin
               vars_ff[7] <= vars_ff[6];
               vars_ff[6] <= vars_ff[5];
               vars_ff[5] <= vars_ff[4];
               vars_ff[4] <= vars_ff[3] + tmp1;
               vars_ff[3] <= vars_ff[2];
               vars_ff[2] <= vars_ff[1];
               vars_ff[1] <= vars_ff[0];
               vars_ff[0] <= tmp1 + tmp2;
               round_ff   <= round_ff + 6'd1;
               if (&round_ff) begin
                  state_ff <= C_ADD;
               end
            end
            C_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + vars_ff[i];
               end
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sha256_stream_hasher_top.sv -----
// SHA-256 stream hasher: byte intake, padding sequencer and digest output.
// A byte that does not fill the block is only packed; one that fills it starts a compression
// (load, 64 rounds on the shared round unit, chaining add, handback), and no new request is
// taken until it ends. A last transaction pads one byte at a time up to byte 56, leaves
// padding, writes the length and runs one or two compressions, then sends eight result
// transactions at one per cycle while rsp_ready is high; reset loads the initial hash, clears length.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_top (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output shs_pkg::rsp_type rsp_data
);
   import shs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMP,
      S_PAD,
      S_LEN,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [63:0]       total_ff, total_in;
   logic              fin_ff, fin_in;
   logic              first_ff, first_in;
   logic              final_ff, final_in;
   logic              start_ff, start_in;
   logic [2:0]        idx_ff, idx_in;

   sched_cmd_type sched_cmd;
   core_cmd_type  core_cmd;
   core_sts_type  core_sts;
   logic [31:0]   sched_word;
   logic [31:0]   chain_word;
   logic          push;
   logic [7:0]    push_val;

   shs_sched u_sched (
      .clock      (clock),
      .sched_cmd  (sched_cmd),
      .shift      (core_sts.shift),
      .sched_word (sched_word)
   );

   shs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .core_cmd   (core_cmd),
      .sched_word (sched_word),
      .core_sts   (core_sts),
      .chain_word (chain_word)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   assign rsp_data.digest_word = chain_word;
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = &idx_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      fin_in   = fin_ff;
      first_in = first_ff;
      final_in = final_ff;
      start_in = 1'b0;
      idx_in   = idx_ff;
      push     = 1'b0;
      push_val = PAD_BYTE;

      sched_cmd.len_wr   = 1'b0;
      sched_cmd.len_bits = total_ff;

      core_cmd.start    = start_ff;
      core_cmd.reinit   = 1'b0;
      core_cmd.word_sel = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fin_in   = req_data.last;
               first_in = 1'b1;
               if (req_data.has_byte) begin
                  push     = 1'b1;
                  push_val = req_data.data_byte;
                  total_in = total_ff + BITS_PER_BYTE;
               end
               if (req_data.has_byte && (&fill_ff)) begin
                  start_in = 1'b1;
                  state_in = S_COMP;
               end else if (req_data.last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            // Stop at the length slot only after the marker byte is in.
            if (!first_ff && (fill_ff == LEN_FILL)) begin
               state_in = S_LEN;
            end else begin
               push     = 1'b1;
               push_val = first_ff ? PAD_BYTE : 8'h00;
               first_in = 1'b0;
               if (&fill_ff) begin
                  start_in = 1'b1;
                  state_in = S_COMP;
               end
            end
         end
         S_LEN: begin
            sched_cmd.len_wr = 1'b1;
            final_in         = 1'b1;
            start_in         = 1'b1;
            state_in         = S_COMP;
         end
         S_COMP: begin
            if (core_sts.done) begin
               if (final_ff) begin
                  idx_in   = '0;
                  state_in = S_OUT;
               end else if (fin_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (&idx_ff) begin
                  core_cmd.reinit = 1'b1;
                  fill_in         = '0;
                  total_in        = '0;
                  fin_in          = 1'b0;
                  final_in        = 1'b0;
                  state_in        = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push) begin
         fill_in = fill_ff + 6'd1;
      end

      sched_cmd.byte_wr  = push;
      sched_cmd.word_sel = fill_ff[5:2];
      sched_cmd.byte_val = push_val;
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         fin_ff   <= 1'b0;
         first_ff <= 1'b0;
         final_ff <= 1'b0;
         start_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         fin_ff   <= fin_in;
         first_ff <= first_in;
         final_ff <= final_in;
         start_ff <= start_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sha256_stream_hasher_checker.sv -----
// Checker for the SHA-256 stream hasher: predicts each digest and compares the result stream.
`timescale 1ns / 1ps

module sha256_stream_hasher_checker (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  wire              req_ready,
   input  shs_pkg::req_type req_data,
   input  wire              rsp_valid,
   input  wire              rsp_ready,
   input  shs_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   localparam int REPORT_LIMIT = 10;

   // Predicted hashing state.
   logic [31:0]      hash_state [8];
   logic [31:0]      msg_words [16];
   int unsigned      byte_fill;
   logic [63:0]      bit_count;

   // Digest words still to be seen on the result channel, oldest first.
   shs_pkg::rsp_type digest_queue [$];

   // Rotate right, written as a slice of the doubled word.
   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] doubled;
      doubled = {x, x} >> n;
      return doubled[31:0];
   endfunction

   // One 64-round compression of msg_words into hash_state.
   task automatic compress_block();
      logic [31:0] sched [64];
      logic [31:0] wv [8];
      logic [31:0] s0, s1, t1, t2, chs, maj;
      int          t;
      for (t = 0; t < 16; t++) begin
         sched[t] = msg_words[t];
      end
      for (t = 16; t < 64; t++) begin
         s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      for (t = 0; t < 8; t++) begin
         wv[t] = hash_state[t];
      end
      for (t = 0; t < 64; t++) begin
         s1  = ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25);
         chs = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
         t1  = wv[7] + s1 + chs + shs_pkg::ROUND_CONSTS[t] + sched[t];
         s0  = ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22);
         maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
         t2  = s0 + maj;
         wv[7] = wv[6];
         wv[6] = wv[5];
         wv[5] = wv[4];
         wv[4] = wv[3] + t1;
         wv[3] = wv[2];
         wv[2] = wv[1];
         wv[1] = wv[0];
         wv[0] = t1 + t2;
      end
      for (t = 0; t < 8; t++) begin
         hash_state[t] = hash_state[t] + wv[t];
      end
   endtask

   // Shift one byte into the block, compressing when the block is full.
   task automatic absorb_byte(input logic [7:0] value);
      int unsigned w;
      w = byte_fill >> 2;
      msg_words[w] = {msg_words[w][23:0], value};
      byte_fill++;
      if (byte_fill == 64) begin
         compress_block();
         byte_fill = 0;
      end
   endtask

   // Pad, append the length, compress and queue the eight digest words.
   task automatic finish_message();
      logic [63:0]      msg_len;
      logic             extra;
      shs_pkg::rsp_type word;
      int               k;
      msg_len = bit_count;
      extra   = (byte_fill >= shs_pkg::LEN_FILL);
      absorb_byte(shs_pkg::PAD_BYTE);
      if (extra) begin
         while (byte_fill != 0) absorb_byte(8'h00);
      end
      while (byte_fill < shs_pkg::LEN_FILL) absorb_byte(8'h00);
      msg_words[14] = msg_len[63:32];
      msg_words[15] = msg_len[31:0];
      compress_block();
      byte_fill = 0;
      for (k = 0; k < 8; k++) begin
         word.digest_word = hash_state[k];
         word.word_index  = 3'(k);
         word.last_word   = (k == 7);
         digest_queue.push_back(word);
      end
      for (k = 0; k < 8; k++) begin
         hash_state[k] = shs_pkg::INIT_WORDS[k];
      end
      bit_count = '0;
   endtask

   // Predict on every input transaction and check every result transaction.
   always @(posedge clock) begin
      shs_pkg::rsp_type want;
      if (reset) begin
         for (int k = 0; k < 8; k++) hash_state[k] = shs_pkg::INIT_WORDS[k];
         for (int k = 0; k < 16; k++) msg_words[k] = '0;
         byte_fill = 0;
         bit_count = '0;
         digest_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.has_byte) begin
               bit_count = bit_count + shs_pkg::BITS_PER_BYTE;
               absorb_byte(req_data.data_byte);
            end
            if (req_data.last) finish_message();
         end
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: unexpected result word=%h index=%0d last=%b", $realtime,
                           rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               error_count = error_count + 1;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_data.digest_word !== want.digest_word ||
                   rsp_data.word_index !== want.word_index ||
                   rsp_data.last_word !== want.last_word) begin
                  if (error_count < REPORT_LIMIT)
                     $display({"%0t: mismatch expected word=%h index=%0d last=%b, ",
                               "got word=%h index=%0d last=%b"},
                              $realtime, want.digest_word, want.word_index, want.last_word,
                              rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
                  error_count = error_count + 1;
               end
            end
         end
      end
      pending_count = digest_queue.size();
   end

endmodule

// ----- tb/tb_sha256_stream_hasher_top.sv -----
// Testbench top for the SHA-256 stream hasher: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

   localparam int RANDOM_ITEMS = 270;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 200;
   localparam int LIMIT_CYCLES = 500000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   shs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   shs_pkg::rsp_type rsp_data;

   int               error_count;
   int               pending_count;
   int               cycle_count = 0;
   int               items_sent = 0;
   bit               req_idle_en = 1'b1;
   bit               rsp_idle_en = 1'b1;
   int               hold_requests = 0;

   sha256_stream_hasher_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sha256_stream_hasher_checker hash_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_en) begin
            rsp_ready <= ($urandom_range(0, 99) >= 32);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one input transaction and wait until it is accepted.
   task automatic send_item(input logic [7:0] value, input logic has, input logic fin);
      while (req_idle_en && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.data_byte <= value;
      req_data.has_byte  <= has;
      req_data.last      <= fin;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent = items_sent + 1;
   endtask

   // Send a message of random bytes with some ignored items mixed in.
   task automatic send_message(input int unsigned nbytes);
      bit byte_on_last;
      byte_on_last = (nbytes != 0) && $urandom_range(0, 1);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 99) < 10) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, byte_on_last && (i == nbytes - 1));
      end
      if (!byte_on_last) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Hold the sender until every predicted digest word has arrived.
   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      int          msg_count;
      int unsigned pick;
      int unsigned nbytes;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty message.
      send_item(8'h00, 1'b0, 1'b1);
      // An item with no byte and no last is ignored; then "abc" ending on a byte.
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Extreme byte values, closed by an empty final transaction.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      wait_drained();

      // Random messages, weighted toward short ones and the padding boundary.
      msg_count = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) nbytes = $urandom_range(0, 10);
         else if (pick < 95) nbytes = $urandom_range(54, 65);
         else nbytes = $urandom_range(120, 135);
         // Keep the total close to the planned item count.
         if (nbytes > RANDOM_ITEMS - items_sent) nbytes = RANDOM_ITEMS - items_sent;

         // The receiver holds off while the sender keeps going.
         if (msg_count == 2) hold_requests = hold_requests + 1;
         // The sender pauses for the block to drain, then a stretch with no idling.
         if (msg_count == 6) begin
            wait_drained();
            req_idle_en = 1'b0;
            rsp_idle_en = 1'b0;
         end
         if (msg_count == 9) begin
            req_idle_en = 1'b1;
            rsp_idle_en = 1'b1;
         end
         send_message(nbytes);
         msg_count = msg_count + 1;
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
